### rtl/gbpre_pkg.sv
// ----------------------------------------------------------------------------
// gbpre_pkg
// shared constants and types for the glyph bitmap pixel run expander
// ----------------------------------------------------------------------------
package gbpre_pkg;

  localparam int unsigned CELL_WIDTH_P  = 12;
  localparam int unsigned CELL_HEIGHT_P = 19;

  localparam logic [6:0] CELL_WIDTH  = 7'(CELL_WIDTH_P);
  localparam logic [6:0] CELL_HEIGHT = 7'(CELL_HEIGHT_P);

  localparam logic [6:0] MAX_WIDTH = 7'd64;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [7:0] MASK_ALL   = 8'hff;
  localparam logic [7:0] MASK_LOW7  = 8'h7f;
  localparam logic [7:0] MASK_LOW6  = 8'h3f;
  localparam logic [7:0] MASK_LOW5  = 8'h1f;
  localparam logic [7:0] MASK_LOW4  = 8'h0f;
  localparam logic [7:0] MASK_PIXEL = 8'h01;

  typedef enum logic [2:0] {
    REG_FG_RED   = 3'd0,
    REG_FG_GREEN = 3'd1,
    REG_FG_BLUE  = 3'd2,
    REG_BG_RED   = 3'd3,
    REG_BG_GREEN = 3'd4,
    REG_BG_BLUE  = 3'd5
  } reg_idx_t;

endpackage

### rtl/gbpre_bitmap_if.sv
// ----------------------------------------------------------------------------
// gbpre_bitmap_if
// request channel carrying one glyph bitmap byte with its row width
// ----------------------------------------------------------------------------
interface gbpre_bitmap_if;
  logic       valid;
  logic       ready;
  logic [7:0] row_bits;
  logic [6:0] row_width;
  logic       first_of_glyph;

  modport source (output valid, output row_bits, output row_width,
                  output first_of_glyph, input ready);
  modport sink   (input valid, input row_bits, input row_width,
                  input first_of_glyph, output ready);
endinterface

### rtl/gbpre_run_if.sv
// ----------------------------------------------------------------------------
// gbpre_run_if
// request channel carrying one pixel write run
// ----------------------------------------------------------------------------
interface gbpre_run_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic [6:0] run_length;
  logic       is_foreground;
  logic       is_padding;
  logic       row_done;
  logic       glyph_done;
  logic       last_of_item;

  modport source (output valid, output pixel_red, output pixel_green,
                  output pixel_blue, output run_length, output is_foreground,
                  output is_padding, output row_done, output glyph_done,
                  output last_of_item, input ready);
  modport sink   (input valid, input pixel_red, input pixel_green,
                  input pixel_blue, input run_length, input is_foreground,
                  input is_padding, input row_done, input glyph_done,
                  input last_of_item, output ready);
endinterface

### rtl/glyph_bitmap_pixel_run_expander.sv
// ----------------------------------------------------------------------------
// glyph_bitmap_pixel_run_expander
// expands glyph bitmap bytes into foreground and background pixel runs
// ----------------------------------------------------------------------------
// Each accepted bitmap byte is registered and then turned into its runs by
// a single run unit (subtracts, adds and compares against the glyph width
// and the cell width) that produces one run per cycle into the output
// register while the run channel does not stall. A byte yields 1 to 9 runs,
// and bitmap.ready is high only between bytes. A run channel stall holds the
// sequencer until the output register frees up. Colors come from the APB
// registers at the time each run is produced; write them only while no byte
// is in flight.
// ----------------------------------------------------------------------------
module glyph_bitmap_pixel_run_expander
  import gbpre_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  gbpre_bitmap_if.sink        bitmap,
  gbpre_run_if.source         runs
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_SINGLE,
    S_PAD
  } state_t;

  state_t     state;
  state_t     state_next;

  logic [7:0] fg_red, fg_green, fg_blue;
  logic [7:0] bg_red, bg_green, bg_blue;

  logic [6:0] col;
  logic [5:0] row;
  logic [6:0] width;
  logic [7:0] sh;
  logic [3:0] pos;
  logic [3:0] run_k;
  logic       run_fore;

  logic       out_valid;
  logic [7:0] out_red, out_green, out_blue;
  logic [6:0] out_len;
  logic       out_fore, out_pad, out_row_done, out_glyph_done, out_last;

  // accept side
  logic       accept;
  logic [6:0] w_in;
  logic [6:0] col_start;
  logic [3:0] k_in;
  logic       fore_in;
  logic [7:0] b_in;

  // run unit
  logic       advance;
  logic [6:0] remain;
  logic [6:0] step_len;
  logic       step_fore;
  logic [6:0] col_sum;
  logic [3:0] pos_sum;
  logic       more_single;
  logic       need_pad;
  logic       step_row_done;
  logic       step_last;
  logic       step_glyph_done;

  logic       cfg_write;
  reg_idx_t   cfg_idx;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_t'(paddr[4:2]);

  always_comb begin
    case (cfg_idx)
      REG_FG_RED:   prdata = {24'd0, fg_red};
      REG_FG_GREEN: prdata = {24'd0, fg_green};
      REG_FG_BLUE:  prdata = {24'd0, fg_blue};
      REG_BG_RED:   prdata = {24'd0, bg_red};
      REG_BG_GREEN: prdata = {24'd0, bg_green};
      REG_BG_BLUE:  prdata = {24'd0, bg_blue};
      default:      prdata = '0;
    endcase
  end

  // byte classification
  assign bitmap.ready = (state == S_IDLE);
  assign accept       = bitmap.valid && bitmap.ready;
  assign b_in         = bitmap.row_bits;

  always_comb begin
    if (bitmap.row_width == 7'd0) begin
      w_in = 7'd1;
    end else if (bitmap.row_width > MAX_WIDTH) begin
      w_in = MAX_WIDTH;
    end else begin
      w_in = bitmap.row_width;
    end
    if (bitmap.first_of_glyph || (col >= w_in)) begin
      col_start = 7'd0;
    end else begin
      col_start = col;
    end
  end

  always_comb begin
    k_in    = 4'd0;
    fore_in = 1'b0;
    if ((b_in == 8'h00) || (b_in == MASK_ALL)) begin
      k_in    = 4'd8;
      fore_in = b_in[0];
    end else if ((b_in & MASK_LOW7) == 8'h00) begin
      k_in = 4'd7;
    end else if ((b_in & MASK_LOW7) == MASK_LOW7) begin
      k_in    = 4'd7;
      fore_in = 1'b1;
    end else if ((b_in & MASK_LOW6) == 8'h00) begin
      k_in = 4'd6;
    end else if ((b_in & MASK_LOW6) == MASK_LOW6) begin
      k_in    = 4'd6;
      fore_in = 1'b1;
    end else if ((b_in & MASK_LOW5) == 8'h00) begin
      k_in = 4'd5;
    end else if ((b_in & MASK_LOW5) == MASK_LOW5) begin
      k_in    = 4'd5;
      fore_in = 1'b1;
    end else if ((b_in & MASK_LOW4) == 8'h00) begin
      k_in = 4'd4;
    end else if ((b_in & MASK_LOW4) == MASK_LOW4) begin
      k_in    = 4'd4;
      fore_in = 1'b1;
    end
  end

  // shared run unit
  assign advance = (state != S_IDLE) && (!out_valid || runs.ready);
  assign remain  = width - col;

  always_comb begin
    case (state)
      S_RUN: begin
        step_len  = (remain < {3'd0, run_k}) ? remain : {3'd0, run_k};
        step_fore = run_fore;
      end
      S_SINGLE: begin
        step_len  = 7'd1;
        step_fore = (sh & MASK_PIXEL) != 8'h00;
      end
      S_PAD: begin
        step_len  = CELL_WIDTH - col;
        step_fore = 1'b0;
      end
      default: begin
        step_len  = 7'd0;
        step_fore = 1'b0;
      end
    endcase
    col_sum = col + step_len;
    pos_sum = pos + step_len[3:0];
    if (state == S_PAD) begin
      more_single   = 1'b0;
      need_pad      = 1'b0;
      step_row_done = 1'b1;
    end else begin
      more_single   = (pos_sum < 4'd8) && (col_sum < width);
      need_pad      = !more_single && (col_sum >= width) && (col_sum < CELL_WIDTH);
      step_row_done = (col_sum >= width) && !need_pad;
    end
    step_last       = !more_single && !need_pad;
    step_glyph_done = step_row_done && (({1'b0, row} + 7'd1) >= CELL_HEIGHT);
    if (more_single) begin
      state_next = S_SINGLE;
    end else if (need_pad) begin
      state_next = S_PAD;
    end else begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      col       <= 7'd0;
      row       <= 6'd0;
      fg_red    <= 8'd255;
      fg_green  <= 8'd255;
      fg_blue   <= 8'd0;
      bg_red    <= 8'd0;
      bg_green  <= 8'd0;
      bg_blue   <= 8'd0;
    end else begin
      if (cfg_write) begin
        case (cfg_idx)
          REG_FG_RED:   fg_red   <= pwdata[7:0];
          REG_FG_GREEN: fg_green <= pwdata[7:0];
          REG_FG_BLUE:  fg_blue  <= pwdata[7:0];
          REG_BG_RED:   bg_red   <= pwdata[7:0];
          REG_BG_GREEN: bg_green <= pwdata[7:0];
          REG_BG_BLUE:  bg_blue  <= pwdata[7:0];
          default: ;
        endcase
      end

      if (advance) begin
        out_valid <= 1'b1;
      end else if (runs.valid && runs.ready) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        width    <= w_in;
        col      <= col_start;
        sh       <= b_in;
        pos      <= 4'd0;
        run_k    <= k_in;
        run_fore <= fore_in;
        if (bitmap.first_of_glyph) begin
          row <= 6'd0;
        end
        state <= (k_in != 4'd0) ? S_RUN : S_SINGLE;
      end else if (advance) begin
        out_red        <= step_fore ? fg_red   : bg_red;
        out_green      <= step_fore ? fg_green : bg_green;
        out_blue       <= step_fore ? fg_blue  : bg_blue;
        out_len        <= step_len;
        out_fore       <= step_fore;
        out_pad        <= (state == S_PAD);
        out_row_done   <= step_row_done;
        out_glyph_done <= step_glyph_done;
        out_last       <= step_last;
        sh             <= sh >> step_len[3:0];
        pos            <= pos_sum;
        if (step_row_done) begin
          col <= 7'd0;
          row <= step_glyph_done ? 6'd0 : row + 6'd1;
        end else begin
          col <= col_sum;
        end
        state <= state_next;
      end
    end
  end

  assign runs.valid         = out_valid;
  assign runs.pixel_red     = out_red;
  assign runs.pixel_green   = out_green;
  assign runs.pixel_blue    = out_blue;
  assign runs.run_length    = out_len;
  assign runs.is_foreground = out_fore;
  assign runs.is_padding    = out_pad;
  assign runs.row_done      = out_row_done;
  assign runs.glyph_done    = out_glyph_done;
  assign runs.last_of_item  = out_last;

  // checks
  a_row_in_cell: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, row} < CELL_HEIGHT))
    else $error("row position left the cell");

  a_col_in_width: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RUN) || (state == S_SINGLE)) |-> (col < width))
    else $error("column reached glyph width while pixel runs remain");

  a_row_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_row_done) |-> out_last)
    else $error("row end run is not the last run of its byte");

  a_pad_is_row_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_pad) |-> (out_row_done && !out_fore))
    else $error("padding run is not a background row end");

  a_glyph_done_row: assert property (@(posedge clk) disable iff (rst)
    (advance && step_glyph_done) |=> (row == 6'd0))
    else $error("row did not wrap after the last cell row");

endmodule
